// ===== hdl/image_row_hash_64_core_assert.svh =====
// assertion macros for the row hash core
// no dependencies; included by modules that carry assertions
`ifndef IMAGE_ROW_HASH_64_CORE_ASSERT_SVH
`define IMAGE_ROW_HASH_64_CORE_ASSERT_SVH

// same-cycle implication
`define IRH_ASSERT_HOLDS(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IRH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/irh_pkg.sv =====
// shared types and constants for the row hash core
// no dependencies
`default_nettype none

package irh_pkg;

	localparam int unsigned DIM_BITS    = 16;
	localparam int unsigned OFF_BITS    = DIM_BITS + 2;
	localparam int unsigned HASH_W      = 64;
	localparam int unsigned DIGIT_W     = 16;
	localparam int unsigned MIX_STEPS   = HASH_W / DIGIT_W;
	localparam int unsigned STEP_W      = $clog2(MIX_STEPS);
	localparam int unsigned CHUNK_BYTES = HASH_W / 8;
	localparam int unsigned MIX_SHIFT   = 29;
	localparam int unsigned TAG_SHIFT   = 48;
	localparam int unsigned CFG_IDX_W   = 2;

	typedef logic [HASH_W-1:0]   hash_t;
	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [OFF_BITS-1:0] off_t;
	typedef logic [STEP_W-1:0]   step_t;

	localparam hash_t GOLDEN_SEED  = 64'h9e37_79b9_7f4a_7c15;
	localparam hash_t MIX_MULT     = 64'hff51_afd7_ed55_8ccd;
	localparam hash_t MASK_OFF_XOR = 64'h0000_0000_0000_5555;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_MASK_MODE,
		REG_MASK_ENABLED
	} cfg_reg_t;

	typedef enum logic {
		FUNC_START,
		FUNC_DATA
	} func_t;

endpackage

`default_nettype wire

// ===== hdl/irh_item_if.sv =====
// input channel of the row hash core: start and chunk items
// depends on irh_pkg
`default_nettype none

interface irh_item_if;
	logic                 valid;
	logic                 ready;
	logic                 func;
	irh_pkg::hash_t       chunk_data;

	modport source (output valid, output func, output chunk_data, input ready);
	modport sink (input valid, input func, input chunk_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/irh_result_if.sv =====
// output channel of the row hash core: final image hash
// depends on irh_pkg
`default_nettype none

interface irh_result_if;
	logic           valid;
	logic           ready;
	irh_pkg::hash_t image_hash;

	modport source (output valid, output image_hash, input ready);
	modport sink (input valid, input image_hash, output ready);
endinterface

`default_nettype wire

// ===== hdl/image_row_hash_64_core.sv =====
// row hash core: seeds from the image size, mixes 8-byte row chunks, emits a 64-bit hash
// depends on irh_pkg, irh_item_if, irh_result_if and image_row_hash_64_core_assert.svh
`default_nettype none

// A start item (func 0) is taken in ST_IDLE; for an empty image it produces a hash of 0
// through ST_EMIT. Each data chunk is accepted in ST_IDLE, then runs four multiply steps
// in ST_MUL and one finish step in ST_FIN. A chunk that ends its row exactly on an 8-byte
// boundary runs ST_MUL and ST_FIN twice, since the row tag is mixed in as a second pass.
// The last row adds ST_EMIT to hand the hash to the output register. The multiply steps
// come from the single 16x64 multiply-accumulate unit, which forms each 64-bit product
// one 16-bit digit per cycle. The core takes no item while a mix is running or a result is pending.

`include "image_row_hash_64_core_assert.svh"

module image_row_hash_64_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [irh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [irh_pkg::DIM_BITS-1:0]        cfg_wdata,
	irh_item_if.sink                           item,
	irh_result_if.source                       result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	irh_pkg::dim_t      width_q;
	irh_pkg::dim_t      height_q;
	logic               mask_mode_q;
	logic               mask_enabled_q;
	logic               busy_q;
	irh_pkg::hash_t     hash_q;
	irh_pkg::dim_t      row_q;
	irh_pkg::off_t      off_q;
	logic               pend_tag_q;
	logic               row_end_q;
	irh_pkg::hash_t     x_q;
	irh_pkg::hash_t     mul_q;
	irh_pkg::hash_t     acc_q;
	irh_pkg::step_t     step_q;
	logic               out_valid_q;
	irh_pkg::hash_t     out_hash_q;

	logic               in_xfer;
	logic               empty_img;
	irh_pkg::off_t      row_bytes;
	irh_pkg::off_t      remaining;
	irh_pkg::off_t      off_plus;
	logic               full_chunk;
	irh_pkg::hash_t     tail;
	irh_pkg::hash_t     row_tag;
	irh_pkg::hash_t     seed;
	irh_pkg::hash_t     prod;
	irh_pkg::hash_t     h_fin;
	irh_pkg::dim_t      row_next;
	logic               img_done;
	logic               out_load;

	assign item.ready        = (state_q == ST_IDLE);
	assign in_xfer           = item.valid && item.ready;
	assign result.valid      = out_valid_q;
	assign result.image_hash = out_hash_q;
	assign out_load          = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	always_comb begin
		empty_img  = (width_q == '0) || (height_q == '0);
		row_bytes  = mask_mode_q ? irh_pkg::off_t'(width_q) : {width_q, 2'b00};
		remaining  = (off_q < row_bytes) ? (row_bytes - off_q) : '0;
		full_chunk = remaining >= irh_pkg::off_t'(irh_pkg::CHUNK_BYTES);
		off_plus   = off_q + irh_pkg::off_t'(irh_pkg::CHUNK_BYTES);
		for (int i = 0; i < irh_pkg::CHUNK_BYTES; i++) begin
			tail[8*i +: 8] = (irh_pkg::off_t'(i) < remaining) ? item.chunk_data[8*i +: 8] : 8'h00;
		end
		row_tag = irh_pkg::hash_t'(row_q) << irh_pkg::TAG_SHIFT;
		seed    = irh_pkg::GOLDEN_SEED
			^ (irh_pkg::hash_t'(width_q) << 32)
			^ irh_pkg::hash_t'(height_q);
		if (mask_mode_q && !mask_enabled_q) begin
			seed = seed ^ irh_pkg::MASK_OFF_XOR;
		end
		prod     = irh_pkg::hash_t'(x_q[irh_pkg::DIGIT_W-1:0]) * mul_q;
		h_fin    = acc_q ^ (acc_q >> irh_pkg::MIX_SHIFT);
		row_next = row_q + irh_pkg::dim_t'(1);
		img_done = (row_next == '0) || (row_next >= height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			width_q        <= '0;
			height_q       <= '0;
			mask_mode_q    <= 1'b0;
			mask_enabled_q <= 1'b1;
			busy_q         <= 1'b0;
			hash_q         <= '0;
			row_q          <= '0;
			off_q          <= '0;
			pend_tag_q     <= 1'b0;
			row_end_q      <= 1'b0;
			x_q            <= '0;
			mul_q          <= '0;
			acc_q          <= '0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
			out_hash_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (irh_pkg::cfg_reg_t'(cfg_index))
					irh_pkg::REG_IMAGE_WIDTH:  width_q        <= cfg_wdata;
					irh_pkg::REG_IMAGE_HEIGHT: height_q       <= cfg_wdata;
					irh_pkg::REG_MASK_MODE:    mask_mode_q    <= cfg_wdata[0];
					irh_pkg::REG_MASK_ENABLED: mask_enabled_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (item.func == irh_pkg::FUNC_START) begin
							busy_q <= !empty_img;
							row_q  <= '0;
							off_q  <= '0;
							if (empty_img) begin
								hash_q  <= '0;
								state_q <= ST_EMIT;
							end else begin
								hash_q <= seed;
							end
						end else if (busy_q) begin
							x_q     <= hash_q ^ (full_chunk ? item.chunk_data : (tail ^ row_tag));
							mul_q   <= irh_pkg::MIX_MULT;
							acc_q   <= '0;
							step_q  <= '0;
							state_q <= ST_MUL;
							if (full_chunk) begin
								off_q      <= off_plus;
								pend_tag_q <= (off_plus == row_bytes);
								row_end_q  <= (off_plus == row_bytes);
							end else begin
								pend_tag_q <= 1'b0;
								row_end_q  <= 1'b1;
							end
						end
					end
				end
				ST_MUL: begin
					acc_q  <= acc_q + prod;
					x_q    <= x_q >> irh_pkg::DIGIT_W;
					mul_q  <= mul_q << irh_pkg::DIGIT_W;
					step_q <= step_q + irh_pkg::step_t'(1);
					if (step_q == irh_pkg::step_t'(irh_pkg::MIX_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (pend_tag_q) begin
						hash_q     <= h_fin;
						x_q        <= h_fin ^ row_tag;
						mul_q      <= irh_pkg::MIX_MULT;
						acc_q      <= '0;
						step_q     <= '0;
						pend_tag_q <= 1'b0;
						state_q    <= ST_MUL;
					end else if (row_end_q) begin
						off_q <= '0;
						if (img_done) begin
							busy_q  <= 1'b0;
							row_q   <= '0;
							hash_q  <= (h_fin == '0) ? irh_pkg::hash_t'(1) : h_fin;
							state_q <= ST_EMIT;
						end else begin
							hash_q  <= h_fin;
							row_q   <= row_next;
							state_q <= ST_IDLE;
						end
					end else begin
						hash_q  <= h_fin;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_hash_q <= hash_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`IRH_ASSERT_HOLDS(a_mix_needs_busy, clk, arst_n, state_q == ST_MUL, busy_q, "mix running with no open image")
	`IRH_ASSERT_HOLDS(a_fin_after_steps, clk, arst_n, state_q == ST_FIN, ($past(state_q) == ST_MUL) && ($past(step_q) == irh_pkg::step_t'(irh_pkg::MIX_STEPS - 1)), "finish step without a full multiply")
	`IRH_ASSERT_NEXT(a_empty_start_emits, clk, arst_n, in_xfer && (item.func == irh_pkg::FUNC_START) && empty_img, state_q == ST_EMIT, "empty image start did not emit")
	`IRH_ASSERT_NEXT(a_emit_loads_out, clk, arst_n, out_load, out_valid_q && (state_q == ST_IDLE), "pending hash not moved to output register")

endmodule

`default_nettype wire
